/* rtl/sssd_pkg.sv */
package sssd_pkg;

    // Number of digits sent in the data frame
    localparam int DIGIT_COUNT_DEFAULT = 4;

    // Input item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 2'd1;
    localparam int CFG_DATA_W = 3;

    // Frame command bytes
    localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
    localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;
    localparam logic [7:0] CMD_CTRL_BASE = 8'h80;
    localparam logic [7:0] SEG_DOT       = 8'h80;
    localparam logic [7:0] SEG_BLANK     = 8'h00;

    typedef struct packed {
        logic       op;
        logic [4:0] digit_three;
        logic [4:0] digit_two;
        logic [4:0] digit_one;
        logic [4:0] digit_zero;
        logic       dio_in;
    } in_item_t;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_drive;
        logic busy_res;
        logic load_dropped;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Map a hex code to its segment pattern; codes 16 and up are blank
    function automatic logic [7:0] glyph(input logic [4:0] code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'h3f;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5b;
            5'd3:    seg = 8'h4f;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6d;
            5'd6:    seg = 8'h7d;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7f;
            5'd9:    seg = 8'h6f;
            5'd10:   seg = 8'h77;
            5'd11:   seg = 8'h7c;
            5'd12:   seg = 8'h39;
            5'd13:   seg = 8'h5e;
            5'd14:   seg = 8'h79;
            5'd15:   seg = 8'h71;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

/* rtl/sssd_if.sv */
// Input item channel
interface sssd_in_if;
    logic               valid;
    logic               ready;
    sssd_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result item channel
interface sssd_out_if;
    logic                valid;
    logic                ready;
    sssd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface sssd_cfg_if;
    logic              valid;
    logic              ready;
    sssd_pkg::cfg_wr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/seven_segment_serial_display_writer_unit.sv */
// Channel   | Role | Payload
// ----------+------+-----------------------------------------------------------
// items     | sink | op, digit_three..digit_zero, dio_in
// results   | src  | clk_level, dio_level, dio_drive, busy_res, load_dropped
// cfg       | sink | index (0 brightness, 1 display_on), data
//
// One item per cycle sustained while results are taken; each item passes through the input
// register, then one sequencer step into the result register.
// The sequencer advances one step per tick item; the 2/3/5 tick waits count items.
// rst_n resets the sequencer, pins, dot flag and config; segment bytes are not reset.
// A stalled result holds the result register; the input register then holds too
// and items is ready again as soon as the pending result is taken.
module seven_segment_serial_display_writer_unit #(
    parameter int DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    sssd_in_if.sink       items,
    sssd_out_if.source    results,
    sssd_cfg_if.sink      cfg
);

    localparam int SEG_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [2:0] DATA_FRAME_LEN = 3'(1 + DIGIT_COUNT);
    localparam logic [2:0] DIGIT_LIMIT    = 3'(DIGIT_COUNT);

    // Sequencer phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START1   = 4'd1;
    localparam logic [3:0] PH_START2   = 4'd2;
    localparam logic [3:0] PH_BIT_LO   = 4'd3;
    localparam logic [3:0] PH_BIT_HI   = 4'd4;
    localparam logic [3:0] PH_ACK_LO   = 4'd5;
    localparam logic [3:0] PH_ACK_REL  = 4'd6;
    localparam logic [3:0] PH_ACK_POLL = 4'd7;
    localparam logic [3:0] PH_ACK_END  = 4'd8;
    localparam logic [3:0] PH_STOP1    = 4'd9;
    localparam logic [3:0] PH_STOP2    = 4'd10;
    localparam logic [3:0] PH_STOP3    = 4'd11;
    localparam logic [3:0] PH_STOP4    = 4'd12;

    // Frame numbers
    localparam logic [1:0] FRAME_CMD  = 2'd0;
    localparam logic [1:0] FRAME_DATA = 2'd1;
    localparam logic [1:0] FRAME_CTRL = 2'd2;

    logic               in_valid_reg;
    sssd_pkg::in_item_t in_item_reg;
    logic               out_valid_reg;
    sssd_pkg::out_item_t out_item_reg;
    sssd_pkg::out_item_t out_item_next;
    logic               advance;

    logic [2:0] brightness_reg;
    logic       display_on_reg;

    logic [3:0] phase_reg,  phase_next;
    logic [1:0] frame_reg,  frame_next;
    logic [2:0] byte_reg,   byte_next;
    logic [7:0] shift_reg,  shift_next;
    logic [2:0] bit_reg,    bit_next;
    logic [2:0] wait_reg,   wait_next;
    logic       dot_reg,    dot_next;
    logic       clk_reg,    clk_next;
    logic       dio_reg,    dio_next;
    logic [7:0] seg_reg  [DIGIT_COUNT];
    logic [7:0] seg_load [DIGIT_COUNT];
    logic       seg_write;
    logic       dropped;

    logic [4:0] digit_code [4];
    logic [2:0] byte_pick_idx;
    logic [2:0] byte_inc;
    logic [2:0] seg_sel;
    logic [7:0] byte_pick;
    logic [2:0] frame_len;

    // Handshakes
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready   = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_item_reg;

    // Capture input transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            in_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_item_reg <= items.data;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 3'd1;
            display_on_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                sssd_pkg::CFG_BRIGHTNESS: brightness_reg <= cfg.data.data;
                sssd_pkg::CFG_DISPLAY_ON: display_on_reg <= cfg.data.data[0];
                default: ;
            endcase
        end
    end

    // Map digit codes to segment bytes for a load
    assign digit_code[0] = in_item_reg.digit_three;
    assign digit_code[1] = in_item_reg.digit_two;
    assign digit_code[2] = in_item_reg.digit_one;
    assign digit_code[3] = in_item_reg.digit_zero;

    for (genvar k = 0; k < DIGIT_COUNT; k++)
    begin : g_seg
        logic [7:0] base;
        if (k < 4)
        begin : g_digit
            assign base = sssd_pkg::glyph(digit_code[k]);
        end
        else
        begin : g_blank
            assign base = sssd_pkg::SEG_BLANK;
        end
        if (k == 1)
        begin : g_dot
            assign seg_load[k] = base | (dot_reg ? sssd_pkg::SEG_BLANK : sssd_pkg::SEG_DOT);
        end
        else
        begin : g_plain
            assign seg_load[k] = base;
        end
    end

    // Pick the next byte of the current frame
    assign byte_inc      = byte_reg + 3'd1;
    assign byte_pick_idx = (phase_reg == PH_START2) ? 3'd0 : byte_inc;
    assign seg_sel       = byte_pick_idx - 3'd1;
    assign frame_len     = (frame_reg == FRAME_DATA) ? DATA_FRAME_LEN : 3'd1;

    always_comb
    begin
        if (frame_reg == FRAME_CMD)
        begin
            byte_pick = sssd_pkg::CMD_DATA_AUTO;
        end
        else if (frame_reg == FRAME_DATA)
        begin
            if (byte_pick_idx == 3'd0)
            begin
                byte_pick = sssd_pkg::CMD_ADDR_ZERO;
            end
            else if (seg_sel < DIGIT_LIMIT)
            begin
                byte_pick = seg_reg[seg_sel[SEG_IDX_W-1:0]];
            end
            else
            begin
                byte_pick = sssd_pkg::SEG_BLANK;
            end
        end
        else
        begin
            byte_pick = sssd_pkg::CMD_CTRL_BASE | {4'b0000, display_on_reg, brightness_reg};
        end
    end

    // Advance the sequencer by one step
    always_comb
    begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        wait_next  = wait_reg;
        dot_next   = dot_reg;
        clk_next   = clk_reg;
        dio_next   = dio_reg;
        seg_write  = 1'b0;
        dropped    = 1'b0;
        if (in_item_reg.op == sssd_pkg::OP_LOAD)
        begin
            if (phase_reg != PH_IDLE)
            begin
                dropped = 1'b1;
            end
            else
            begin
                seg_write  = 1'b1;
                dot_next   = !dot_reg;
                frame_next = FRAME_CMD;
                byte_next  = 3'd0;
                bit_next   = 3'd0;
                clk_next   = 1'b1;
                dio_next   = 1'b1;
                wait_next  = 3'd2;
                phase_next = PH_START2;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (wait_reg != 3'd0)
            begin
                wait_next = wait_reg - 3'd1;
            end
            else
            begin
                case (phase_reg)
                    PH_START1:
                    begin
                        clk_next   = 1'b1;
                        dio_next   = 1'b1;
                        wait_next  = 3'd2;
                        phase_next = PH_START2;
                    end
                    PH_START2:
                    begin
                        dio_next   = 1'b0;
                        byte_next  = 3'd0;
                        shift_next = byte_pick;
                        bit_next   = 3'd0;
                        phase_next = PH_BIT_LO;
                    end
                    PH_BIT_LO:
                    begin
                        clk_next   = 1'b0;
                        dio_next   = shift_reg[0];
                        wait_next  = 3'd3;
                        phase_next = PH_BIT_HI;
                    end
                    PH_BIT_HI:
                    begin
                        clk_next   = 1'b1;
                        shift_next = shift_reg >> 1;
                        wait_next  = 3'd3;
                        if (bit_reg == 3'd7)
                        begin
                            bit_next   = 3'd0;
                            phase_next = PH_ACK_LO;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_BIT_LO;
                        end
                    end
                    PH_ACK_LO:
                    begin
                        clk_next   = 1'b0;
                        wait_next  = 3'd5;
                        phase_next = PH_ACK_REL;
                    end
                    PH_ACK_REL:
                    begin
                        phase_next = PH_ACK_POLL;
                    end
                    PH_ACK_POLL:
                    begin
                        if (!in_item_reg.dio_in)
                        begin
                            clk_next   = 1'b1;
                            wait_next  = 3'd2;
                            phase_next = PH_ACK_END;
                        end
                    end
                    PH_ACK_END:
                    begin
                        clk_next  = 1'b0;
                        byte_next = byte_inc;
                        if (byte_inc < frame_len)
                        begin
                            shift_next = byte_pick;
                            bit_next   = 3'd0;
                            phase_next = PH_BIT_LO;
                        end
                        else
                        begin
                            phase_next = PH_STOP1;
                        end
                    end
                    PH_STOP1:
                    begin
                        clk_next   = 1'b0;
                        wait_next  = 3'd2;
                        phase_next = PH_STOP2;
                    end
                    PH_STOP2:
                    begin
                        dio_next   = 1'b0;
                        wait_next  = 3'd2;
                        phase_next = PH_STOP3;
                    end
                    PH_STOP3:
                    begin
                        clk_next   = 1'b1;
                        wait_next  = 3'd2;
                        phase_next = PH_STOP4;
                    end
                    PH_STOP4:
                    begin
                        dio_next = 1'b1;
                        if (frame_reg != FRAME_CTRL)
                        begin
                            frame_next = frame_reg + 2'd1;
                            phase_next = PH_START1;
                        end
                        else
                        begin
                            frame_next = FRAME_CMD;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = 3'd0;
                    end
                endcase
            end
        end
    end

    // Form the result from the state after this step
    always_comb
    begin
        out_item_next.clk_level    = clk_next;
        out_item_next.dio_level    = dio_next;
        out_item_next.dio_drive    = (phase_next != PH_ACK_POLL);
        out_item_next.busy_res     = (phase_next != PH_IDLE);
        out_item_next.load_dropped = dropped;
    end

    // Update sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            frame_reg <= FRAME_CMD;
            byte_reg  <= 3'd0;
            shift_reg <= 8'd0;
            bit_reg   <= 3'd0;
            wait_reg  <= 3'd0;
            dot_reg   <= 1'b1;
            clk_reg   <= 1'b0;
            dio_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            wait_reg  <= wait_next;
            dot_reg   <= dot_next;
            clk_reg   <= clk_next;
            dio_reg   <= dio_next;
        end
    end

    // Store segment bytes on an accepted load
    always_ff @(posedge clk)
    begin
        if (advance && seg_write)
        begin
            for (int k = 0; k < DIGIT_COUNT; k++)
            begin
                seg_reg[k] <= seg_load[k];
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> (results.valid && !results.ready))
        else $error("input stalled without a pending result");

    // Idle sequencer never carries a pending wait
    a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (wait_reg == 3'd0))
        else $error("wait count left over in idle");

    // Bit counter runs only while shifting a byte
    a_bit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_reg != 3'd0) |-> (phase_reg == PH_BIT_LO || phase_reg == PH_BIT_HI))
        else $error("bit count outside bit phases");

    // A dropped load or a released line means a transfer is under way
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.data.load_dropped || !results.data.dio_drive))
        |-> results.data.busy_res)
        else $error("result not busy while dropping or releasing");

    // A stalled item never changes the dot flag
    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> $stable(dot_reg))
        else $error("dot flag changed during a stall");

endmodule

/* sim/seven_segment_serial_display_writer_unit_tb.sv */
module seven_segment_serial_display_writer_unit_tb;

    localparam int          N_DIGITS    = sssd_pkg::DIGIT_COUNT_DEFAULT;
    localparam int          HOLD_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Hex glyphs, segment a in bit 0
    localparam logic [7:0] HEX_SEGMENTS [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

    // Sequencer steps of the two-wire writer
    localparam logic [3:0] SEQ_IDLE          = 4'd0;
    localparam logic [3:0] SEQ_START_CLK     = 4'd1;
    localparam logic [3:0] SEQ_START_DIO     = 4'd2;
    localparam logic [3:0] SEQ_BIT_LOW       = 4'd3;
    localparam logic [3:0] SEQ_BIT_HIGH      = 4'd4;
    localparam logic [3:0] SEQ_ACK_LOW       = 4'd5;
    localparam logic [3:0] SEQ_ACK_RELEASE   = 4'd6;
    localparam logic [3:0] SEQ_ACK_POLL      = 4'd7;
    localparam logic [3:0] SEQ_ACK_DONE      = 4'd8;
    localparam logic [3:0] SEQ_STOP_CLK_LOW  = 4'd9;
    localparam logic [3:0] SEQ_STOP_DIO_LOW  = 4'd10;
    localparam logic [3:0] SEQ_STOP_CLK_HIGH = 4'd11;
    localparam logic [3:0] SEQ_STOP_DIO_HIGH = 4'd12;

    logic clk;
    logic rst_n;

    sssd_in_if  items_if ();
    sssd_out_if results_if ();
    sssd_cfg_if cfg_if ();

    seven_segment_serial_display_writer_unit #(
        .DIGIT_COUNT (N_DIGITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // Writer model state
    logic [2:0]    cfg_brightness;
    logic          cfg_display_on;
    logic [3:0]    seq_phase;
    logic [1:0]    frame_idx;
    logic [2:0]    byte_idx;
    logic [7:0]    shift_reg;
    logic [2:0]    bit_cnt;
    logic [2:0]    wait_cnt;
    logic [7:0]    seg_bytes [N_DIGITS];
    logic          dot_toggle;
    logic          clk_pin;
    logic          dio_pin;

    // Pin levels still owed by the block, oldest first
    sssd_pkg::out_item_t pending_pins [$];
    int unsigned         mismatches;

    // Traffic shaping knobs
    logic          src_calm;
    logic          sink_calm;
    logic          hold_request;
    logic          hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void reset_writer_model();
        cfg_brightness = 3'd1;
        cfg_display_on = 1'b1;
        seq_phase      = SEQ_IDLE;
        frame_idx      = '0;
        byte_idx       = '0;
        shift_reg      = '0;
        bit_cnt        = '0;
        wait_cnt       = '0;
        dot_toggle     = 1'b1;
        clk_pin        = 1'b0;
        dio_pin        = 1'b0;
        foreach (seg_bytes[k])
            seg_bytes[k] = '0;
    endfunction

    // Drive both lines high and hold for the start setup time
    function automatic void raise_start();
        clk_pin   = 1'b1;
        dio_pin   = 1'b1;
        wait_cnt  = 3'd2;
        seq_phase = SEQ_START_DIO;
    endfunction

    // Pick the next byte of the current frame
    function automatic void fetch_byte();
        if (frame_idx == 2'd0)
            shift_reg = sssd_pkg::CMD_DATA_AUTO;
        else if (frame_idx == 2'd1)
            shift_reg = (byte_idx == 3'd0) ? sssd_pkg::CMD_ADDR_ZERO
                                           : seg_bytes[byte_idx - 3'd1];
        else
            shift_reg = sssd_pkg::CMD_CTRL_BASE
                        | {4'b0000, cfg_display_on, cfg_brightness};
        bit_cnt   = '0;
        seq_phase = SEQ_BIT_LOW;
    endfunction

    // Advance the sequencer by one tick
    function automatic void step_sequencer(input logic dio_sample);
        if (seq_phase == SEQ_IDLE)
            return;
        if (wait_cnt != 3'd0)
        begin
            wait_cnt = wait_cnt - 3'd1;
            return;
        end
        case (seq_phase)
            SEQ_START_CLK:
                raise_start();
            SEQ_START_DIO:
            begin
                dio_pin  = 1'b0;
                byte_idx = '0;
                fetch_byte();
            end
            SEQ_BIT_LOW:
            begin
                clk_pin   = 1'b0;
                dio_pin   = shift_reg[0];
                wait_cnt  = 3'd3;
                seq_phase = SEQ_BIT_HIGH;
            end
            SEQ_BIT_HIGH:
            begin
                clk_pin   = 1'b1;
                shift_reg = shift_reg >> 1;
                wait_cnt  = 3'd3;
                if (bit_cnt >= 3'd7)
                begin
                    bit_cnt   = '0;
                    seq_phase = SEQ_ACK_LOW;
                end
                else
                begin
                    bit_cnt   = bit_cnt + 3'd1;
                    seq_phase = SEQ_BIT_LOW;
                end
            end
            SEQ_ACK_LOW:
            begin
                clk_pin   = 1'b0;
                wait_cnt  = 3'd5;
                seq_phase = SEQ_ACK_RELEASE;
            end
            SEQ_ACK_RELEASE:
                seq_phase = SEQ_ACK_POLL;
            SEQ_ACK_POLL:
            begin
                // Low on the data line is the acknowledge
                if (!dio_sample)
                begin
                    clk_pin   = 1'b1;
                    wait_cnt  = 3'd2;
                    seq_phase = SEQ_ACK_DONE;
                end
            end
            SEQ_ACK_DONE:
            begin
                clk_pin  = 1'b0;
                byte_idx = byte_idx + 3'd1;
                if (byte_idx < ((frame_idx == 2'd1) ? 3'(1 + N_DIGITS) : 3'd1))
                    fetch_byte();
                else
                    seq_phase = SEQ_STOP_CLK_LOW;
            end
            SEQ_STOP_CLK_LOW:
            begin
                clk_pin   = 1'b0;
                wait_cnt  = 3'd2;
                seq_phase = SEQ_STOP_DIO_LOW;
            end
            SEQ_STOP_DIO_LOW:
            begin
                dio_pin   = 1'b0;
                wait_cnt  = 3'd2;
                seq_phase = SEQ_STOP_CLK_HIGH;
            end
            SEQ_STOP_CLK_HIGH:
            begin
                clk_pin   = 1'b1;
                wait_cnt  = 3'd2;
                seq_phase = SEQ_STOP_DIO_HIGH;
            end
            SEQ_STOP_DIO_HIGH:
            begin
                dio_pin = 1'b1;
                if (frame_idx < 2'd2)
                begin
                    frame_idx = frame_idx + 2'd1;
                    seq_phase = SEQ_START_CLK;
                end
                else
                begin
                    frame_idx = '0;
                    seq_phase = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
                wait_cnt  = '0;
            end
        endcase
    endfunction

    // Apply one item to the model and return the pin levels it leaves
    function automatic sssd_pkg::out_item_t predict_pin_levels(input sssd_pkg::in_item_t item);
        sssd_pkg::out_item_t pins;
        logic [4:0]          codes [4];
        logic [4:0]          code;
        logic                dropped;

        dropped = 1'b0;
        codes   = '{item.digit_three, item.digit_two, item.digit_one, item.digit_zero};
        if (item.op == sssd_pkg::OP_LOAD)
        begin
            if (seq_phase != SEQ_IDLE)
                dropped = 1'b1;
            else
            begin
                for (int k = 0; k < N_DIGITS; k++)
                begin
                    code         = (k < 4) ? codes[k] : 5'd16;
                    seg_bytes[k] = (code < 5'd16) ? HEX_SEGMENTS[code[3:0]]
                                                  : sssd_pkg::SEG_BLANK;
                end
                // Dot on the second digit every other load
                if (N_DIGITS >= 2 && !dot_toggle)
                    seg_bytes[1] = seg_bytes[1] | sssd_pkg::SEG_DOT;
                dot_toggle = ~dot_toggle;
                frame_idx  = '0;
                byte_idx   = '0;
                bit_cnt    = '0;
                wait_cnt   = '0;
                raise_start();
            end
        end
        else
            step_sequencer(item.dio_in);

        pins.clk_level    = clk_pin;
        pins.dio_level    = dio_pin;
        pins.dio_drive    = (seq_phase != SEQ_ACK_POLL);
        pins.busy_res     = (seq_phase != SEQ_IDLE);
        pins.load_dropped = dropped;
        return pins;
    endfunction

    function automatic sssd_pkg::in_item_t make_item(input logic op, input logic [4:0] d3,
                                                     input logic [4:0] d2, input logic [4:0] d1,
                                                     input logic [4:0] d0, input logic dio);
        sssd_pkg::in_item_t item;
        item.op          = op;
        item.digit_three = d3;
        item.digit_two   = d2;
        item.digit_one   = d1;
        item.digit_zero  = d0;
        item.dio_in      = dio;
        return item;
    endfunction

    // Favor the table ends and the blank codes
    function automatic logic [4:0] pick_digit();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd15;
            2:       return 5'd16;
            3:       return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    // Offer one item after a random gap and book its pin levels once taken
    task automatic send_item(input sssd_pkg::in_item_t item);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.data  <= item;
        items_if.valid <= 1'b1;
        @(posedge clk);
        while (items_if.ready !== 1'b1)
            @(posedge clk);
        pending_pins.push_back(predict_pin_levels(item));
    endtask

    // Stop offering and let every owed result come out
    task automatic wait_until_drained();
        items_if.valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sssd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sssd_pkg::CFG_DATA_W-1:0] value);
        cfg_if.data.index <= idx;
        cfg_if.data.data  <= value;
        cfg_if.valid      <= 1'b1;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == sssd_pkg::CFG_BRIGHTNESS)
            cfg_brightness = value;
        else if (idx == sssd_pkg::CFG_DISPLAY_ON)
            cfg_display_on = value[0];
        @(posedge clk);
    endtask

    // Mostly complete transfers with random acks, some idle ticks and dropped loads
    task automatic run_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned nack_left;
        logic        dio;
        logic        op;

        sent      = 0;
        nack_left = 0;
        while (sent < n_items || seq_phase != SEQ_IDLE)
        begin
            if (sent != 0 && sent % 128 == 0)
            begin
                src_calm  = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            // Now and then withhold the acknowledge for a long stretch
            if (seq_phase == SEQ_ACK_POLL && nack_left == 0 && $urandom_range(0, 15) == 0)
                nack_left = $urandom_range(20, 60);
            if (nack_left != 0)
            begin
                nack_left--;
                dio = 1'b1;
            end
            else
                dio = ($urandom_range(0, 3) == 0);
            if (seq_phase == SEQ_IDLE)
                op = ($urandom_range(0, 3) == 0) ? sssd_pkg::OP_TICK : sssd_pkg::OP_LOAD;
            else
                op = ($urandom_range(0, 39) == 0) ? sssd_pkg::OP_LOAD : sssd_pkg::OP_TICK;
            send_item(make_item(op, pick_digit(), pick_digit(), pick_digit(), pick_digit(),
                                dio));
            sent++;
        end
    endtask

    // Idle ticks, table ends, blank codes and loads while busy
    task automatic test_idle_and_load();
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        send_item(make_item(sssd_pkg::OP_TICK, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        send_item(make_item(sssd_pkg::OP_TICK, 5'd31, 5'd31, 5'd31, 5'd31, 1'b1));
        send_item(make_item(sssd_pkg::OP_LOAD, 5'd0, 5'd15, 5'd16, 5'd31, 1'b1));
        send_item(make_item(sssd_pkg::OP_LOAD, 5'd31, 5'd31, 5'd31, 5'd31, 1'b1));
        for (int k = 0; k < 6; k++)
            send_item(make_item(sssd_pkg::OP_TICK, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1));
        send_item(make_item(sssd_pkg::OP_LOAD, 5'd10, 5'd5, 5'd30, 5'd1, 1'b0));
        for (int k = 0; k < 8; k++)
            send_item(make_item(sssd_pkg::OP_TICK, 5'd16, 5'd16, 5'd16, 5'd16, 1'b0));
    endtask

    // Run random traffic under the reset settings, then drain
    task automatic test_default_control();
        run_traffic(400);
        wait_until_drained();
    endtask

    task automatic test_config_extremes();
        write_reg(sssd_pkg::CFG_BRIGHTNESS, 3'd7);
        write_reg(sssd_pkg::CFG_DISPLAY_ON, 3'd0);
        src_calm  = 1'b0;
        sink_calm = 1'b1;
        run_traffic(400);
        wait_until_drained();
    endtask

    // Hold the result side off while items keep coming
    task automatic test_output_backpressure();
        write_reg(sssd_pkg::CFG_BRIGHTNESS, 3'd0);
        write_reg(sssd_pkg::CFG_DISPLAY_ON, 3'd1);
        src_calm     = 1'b1;
        sink_calm    = 1'b0;
        hold_request = 1'b1;
        run_traffic(400);
        wait_until_drained();
    endtask

    task automatic compare_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0b, actual %0b", $time, field, want, got);
        end
    endtask

    // Pull results with random stalls
    initial
    begin : result_sink
        int idle_left;
        idle_left = 0;
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (results_if.valid && results_if.ready)
                idle_left = sink_calm ? 0 : $urandom_range(0, 8);
            else if (!results_if.ready && idle_left > 0)
                idle_left--;
            results_if.ready <= (idle_left == 0) && !hold_off;
        end
    end

    // Count out the long hold-off once asked
    initial
    begin : long_holdoff
        hold_off <= 1'b0;
        wait (hold_request === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Check every result transfer against the oldest owed pin levels
    initial
    begin : result_check
        sssd_pkg::out_item_t want;
        sssd_pkg::out_item_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_if.valid && results_if.ready)
            begin
                got = results_if.data;
                if (pending_pins.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual %b", $time, got);
                end
                else
                begin
                    want = pending_pins.pop_front();
                    compare_field("clk_level", want.clk_level, got.clk_level);
                    compare_field("dio_level", want.dio_level, got.dio_level);
                    compare_field("dio_drive", want.dio_drive, got.dio_drive);
                    compare_field("busy_res", want.busy_res, got.busy_res);
                    compare_field("load_dropped", want.load_dropped, got.load_dropped);
                end
            end
        end
    end

    // Bound the run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("seven_segment_serial_display_writer_unit_tb: errors");
        $finish;
    end

    initial
    begin
        mismatches     = 0;
        hold_request   = 1'b0;
        src_calm       = 1'b0;
        sink_calm      = 1'b0;
        items_if.valid <= 1'b0;
        items_if.data  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;
        rst_n          <= 1'b0;
        reset_writer_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_load();
        test_default_control();
        test_config_extremes();
        test_output_backpressure();

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("seven_segment_serial_display_writer_unit_tb: clean");
        else
            $display("seven_segment_serial_display_writer_unit_tb: errors");
        $finish;
    end

endmodule
